FILE: hdl/mer_pkg.sv
`default_nettype none

package mer_pkg;

  // Fixed field widths
  localparam int CRD_W    = 10;  // center and radius fields
  localparam int PIX_W    = 12;  // pixel coordinates
  localparam int RADIUS_BITS_DEF = 10;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_A2,    // rx*rx
    S_B2,    // ry*ry
    S_SY,    // a2*ry
    S_D0,    // initial decision, first part
    S_D1,    // initial decision, second part and region check
    S_E1,    // region two entry: h*h
    S_E2,    // b2*h^2
    S_E3,    // v*v
    S_E4,    // a2*v^2
    S_E5,    // a2*b2
    S_E6,    // finish region two start value
    S_EMIT,  // four pixel beats
    S_U1,    // move point, update slopes
    S_U2,    // decision increment, first term
    S_U3,    // decision increment, second term
    S_U4     // apply increment, region check
  } mer_state_t;

endpackage

`default_nettype wire

FILE: hdl/mer_if.sv
`default_nettype none

interface mer_in_if
  import mer_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [CRD_W-1:0] center_x;
  logic [CRD_W-1:0] center_y;
  logic [CRD_W-1:0] radius_x;
  logic [CRD_W-1:0] radius_y;

  modport source (output valid, cmd, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink   (input valid, cmd, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

interface mer_out_if
  import mer_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    last_of_step;
  logic                    ellipse_done;

  modport source (output valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/midpoint_ellipse_rasterizer.sv
// Channel   Dir  Handshake          Beat payload
// in_ch     in   valid/ready        cmd, center_x, center_y, radius_x, radius_y
// out_ch    out  valid/ready        pixel_x, pixel_y, last_of_step, ellipse_done
//
// Start: after the accept the block forms a2, b2 and a2*ry and makes two decision
// adds, then runs the region two entry steps when a zero radius puts the point there at once.
// Step: 4 pixel beats (one per cycle while out_ch.ready is high), then the update states
// U1 to U4, only U1 on the final step, plus the entry steps on the step where region two begins.
// All products share one multiplier; in_ch.ready is high only when idle.
// Reset leaves the block idle; a step's last beat may wait while the next command is taken.
`default_nettype none

module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);

  localparam int XW = RADIUS_BITS + 1;      // point coordinates
  localparam int SQW = 2 * RADIUS_BITS;     // squared radii
  localparam int MW = 2 * RADIUS_BITS + 4;  // multiplier operands
  localparam int DW = 2 * MW;               // decision and slopes

  // State
  mer_state_t state_r, state_nxt;
  logic       active_r, active_nxt;
  logic       r2_r, r2_nxt;
  logic       br_r, br_nxt;
  logic [1:0] k_r, k_nxt;

  logic [CRD_W-1:0]       cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RADIUS_BITS-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [SQW-1:0]         a2_r, a2_nxt, b2_r, b2_nxt;
  logic [XW-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic signed [DW-1:0]   dec_r, dec_nxt, sx_r, sx_nxt, sy_r, sy_nxt, t_r, t_nxt;

  logic                    ov_r, ov_nxt;
  logic signed [PIX_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                    last_r, last_nxt, done_r, done_nxt;

  // Shared multiplier
  logic          mul_en;
  logic [MW-1:0] mul_a, mul_b;
  logic [DW-1:0] prod;

  mer_mul #(.MW(MW)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Derived values
  logic [CRD_W+RADIUS_BITS-1:0] rx_ext, ry_ext;
  logic [XW+PIX_W-1:0]          x_ext, y_ext;
  logic [PIX_W-1:0]             cxp, cyp, xp, yp;
  logic [XW-1:0]                vabs;
  logic [XW:0]                  hval;
  logic signed [DW-1:0]         a2s, b2s, ps;
  logic                         in_acc, out_take, load_pix, pt_done;

  assign rx_ext = {{RADIUS_BITS{1'b0}}, in_ch.radius_x};
  assign ry_ext = {{RADIUS_BITS{1'b0}}, in_ch.radius_y};
  assign x_ext  = {{PIX_W{1'b0}}, x_r};
  assign y_ext  = {{PIX_W{1'b0}}, y_r};
  assign cxp    = PIX_W'(cx_r);
  assign cyp    = PIX_W'(cy_r);
  assign xp     = x_ext[PIX_W-1:0];
  assign yp     = y_ext[PIX_W-1:0];
  assign vabs   = (y_r == '0) ? XW'(1) : y_r - XW'(1);
  assign hval   = {x_r, 1'b1};
  assign a2s    = $signed(DW'(a2_r));
  assign b2s    = $signed(DW'(b2_r));
  assign ps     = $signed(prod);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_take    = ov_r && out_ch.ready;
  assign load_pix    = (state_r == S_EMIT) && (!ov_r || out_ch.ready);
  assign pt_done     = r2_r && (y_r == '0);

  // Sequencer and datapath next values
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    r2_nxt     = r2_r;
    br_nxt     = br_r;
    k_nxt      = k_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    a2_nxt     = a2_r;
    b2_nxt     = b2_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    t_nxt      = t_r;
    mul_en     = 1'b0;
    mul_a      = MW'(rx_r);
    mul_b      = MW'(rx_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_START) begin
            cx_nxt     = in_ch.center_x;
            cy_nxt     = in_ch.center_y;
            rx_nxt     = rx_ext[RADIUS_BITS-1:0];
            ry_nxt     = ry_ext[RADIUS_BITS-1:0];
            x_nxt      = '0;
            y_nxt      = XW'(ry_ext[RADIUS_BITS-1:0]);
            sx_nxt     = '0;
            sy_nxt     = '0;
            r2_nxt     = 1'b0;
            active_nxt = 1'b1;
            state_nxt  = S_A2;
          end else if (active_r) begin
            k_nxt     = 2'd0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_A2: begin
        mul_en    = 1'b1;
        state_nxt = S_B2;
      end
      S_B2: begin
        a2_nxt    = SQW'(prod);
        mul_en    = 1'b1;
        mul_a     = MW'(ry_r);
        mul_b     = MW'(ry_r);
        state_nxt = S_SY;
      end
      S_SY: begin
        b2_nxt    = SQW'(prod);
        mul_en    = 1'b1;
        mul_a     = MW'(a2_r);
        mul_b     = MW'(ry_r);
        state_nxt = S_D0;
      end
      S_D0: begin
        // sy = 2*a2*ry, dec = 4*b2 + a2
        sy_nxt    = ps <<< 1;
        dec_nxt   = (b2s <<< 2) + a2s;
        state_nxt = S_D1;
      end
      S_D1: begin
        // subtract 4*a2*ry
        dec_nxt   = dec_r - (sy_r <<< 1);
        state_nxt = (sx_r >= sy_r) ? S_E1 : S_IDLE;
      end
      S_E1: begin
        mul_en    = 1'b1;
        mul_a     = MW'(hval);
        mul_b     = MW'(hval);
        state_nxt = S_E2;
      end
      S_E2: begin
        mul_en    = 1'b1;
        mul_a     = MW'(b2_r);
        mul_b     = MW'(prod);
        state_nxt = S_E3;
      end
      S_E3: begin
        dec_nxt   = ps;
        mul_en    = 1'b1;
        mul_a     = MW'(vabs);
        mul_b     = MW'(vabs);
        state_nxt = S_E4;
      end
      S_E4: begin
        mul_en    = 1'b1;
        mul_a     = MW'(a2_r);
        mul_b     = MW'(prod);
        state_nxt = S_E5;
      end
      S_E5: begin
        dec_nxt   = dec_r + (ps <<< 2);
        mul_en    = 1'b1;
        mul_a     = MW'(a2_r);
        mul_b     = MW'(b2_r);
        state_nxt = S_E6;
      end
      S_E6: begin
        dec_nxt   = dec_r - (ps <<< 2);
        r2_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (load_pix) begin
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_nxt = S_U1;
          end
        end
      end
      S_U1: begin
        if (pt_done) begin
          active_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end else begin
          // region one always steps x, region two always steps y
          br_nxt = r2_r ? (dec_r > 0) : (dec_r < 0);
          if (!r2_r || !br_nxt) begin
            x_nxt  = x_r + XW'(1);
            sx_nxt = sx_r + (b2s <<< 1);
          end
          if (r2_r || !br_nxt) begin
            y_nxt  = y_r - XW'(1);
            sy_nxt = sy_r - (a2s <<< 1);
          end
          state_nxt = S_U2;
        end
      end
      S_U2: begin
        if (br_r) begin
          t_nxt = r2_r ? -sy_r : sx_r;
        end else begin
          t_nxt = sx_r - sy_r;
        end
        state_nxt = S_U3;
      end
      S_U3: begin
        t_nxt     = t_r + (r2_r ? a2s : b2s);
        state_nxt = S_U4;
      end
      S_U4: begin
        dec_nxt   = dec_r + (t_r <<< 2);
        state_nxt = (!r2_r && (sx_r >= sy_r)) ? S_E1 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    ov_nxt   = ov_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    last_nxt = last_r;
    done_nxt = done_r;
    if (out_take) begin
      ov_nxt = 1'b0;
    end
    if (load_pix) begin
      ov_nxt   = 1'b1;
      px_nxt   = (k_r == 2'd1 || k_r == 2'd2) ? $signed(cxp - xp) : $signed(cxp + xp);
      py_nxt   = k_r[1] ? $signed(cyp - yp) : $signed(cyp + yp);
      last_nxt = (k_r == 2'd3);
      done_nxt = (k_r == 2'd3) && pt_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      r2_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      r2_r     <= r2_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    br_r   <= br_nxt;
    k_r    <= k_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dec_r  <= dec_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    t_r    <= t_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.pixel_x      = px_r;
  assign out_ch.pixel_y      = py_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.ellipse_done = done_r;

`ifndef SYNTHESIS
  // A new pixel beat only comes out of the emit phase
  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_EMIT)
    else $error("pixel beat outside emit phase");

  // A start command always goes to the squaring sequence
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_START) |=> state_r == S_A2)
    else $error("start command did not begin setup");

  // In region two the x slope never falls below the y slope
  a_region_two: assert property (@(posedge clk) disable iff (!rst_n)
    r2_r |-> sx_r >= sy_r)
    else $error("region two with x slope below y slope");

  // Done mark only on the closing beat of a step
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ellipse_done) |-> out_ch.last_of_step)
    else $error("done mark off the last beat");
`endif

endmodule

`default_nettype wire

FILE: hdl/mer_mul.sv
`default_nettype none

// Shared unsigned multiplier with registered product
module mer_mul
  import mer_pkg::*;
#(
  parameter int MW = 2 * RADIUS_BITS_DEF + 4
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [MW-1:0]   op_a,
  input  wire logic [MW-1:0]   op_b,
  output logic      [2*MW-1:0] prod
);

  logic [2*MW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: tb/ellipse_pixel_checker.sv
module ellipse_pixel_checker
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mer_in_if    in_ch,
  mer_out_if   out_ch,
  output int   mismatch_count,
  output int   pixels_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CRD_W-1:0] RADIUS_MASK = CRD_W'((64'd1 << RADIUS_BITS) - 1);

  typedef struct packed {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic                    last;
    logic                    done;
  } pixel_beat_t;

  pixel_beat_t expected_pixels[$];

  // Shadow of the rasterizer state
  logic                tracing;
  logic                region_two;
  logic [CRD_W-1:0]    ctr_x, ctr_y, rad_x, rad_y;
  longint              pt_x, pt_y;
  longint              dec, slope_x, slope_y;

  function automatic longint sq(input logic [CRD_W-1:0] r);
    return longint'(r) * longint'(r);
  endfunction

  // Region two opens with the decision re-evaluated at the current point
  function automatic void enter_region_two();
    longint a2, b2, h, v;
    a2 = sq(rad_x);
    b2 = sq(rad_y);
    h = 2 * pt_x + 1;
    v = pt_y - 1;
    region_two = 1'b1;
    dec = b2 * h * h + 4 * a2 * v * v - 4 * a2 * b2;
  endfunction

  function automatic void push_pixel(input int px, input int py, input logic last,
                                     input logic done);
    pixel_beat_t b;
    b.px = px[PIX_W-1:0];
    b.py = py[PIX_W-1:0];
    b.last = last;
    b.done = done;
    expected_pixels.push_back(b);
  endfunction

  // One accepted command: latch a new ellipse, or emit a quadruple and advance
  function automatic void advance_ellipse(input logic cmd, input logic [CRD_W-1:0] cx,
                                          input logic [CRD_W-1:0] cy,
                                          input logic [CRD_W-1:0] rx,
                                          input logic [CRD_W-1:0] ry);
    longint a2, b2;
    int     xc, yc, xi, yi;
    logic   done;
    if (cmd == CMD_START) begin
      ctr_x = cx;
      ctr_y = cy;
      rad_x = rx & RADIUS_MASK;
      rad_y = ry & RADIUS_MASK;
      a2 = sq(rad_x);
      b2 = sq(rad_y);
      pt_x = 0;
      pt_y = longint'(rad_y);
      slope_x = 0;
      slope_y = 2 * a2 * pt_y;
      dec = 4 * b2 - 4 * a2 * longint'(rad_y) + a2;
      region_two = 1'b0;
      tracing = 1'b1;
      if (slope_x >= slope_y) enter_region_two();
      return;
    end
    if (!tracing) return;

    a2 = sq(rad_x);
    b2 = sq(rad_y);
    xc = int'(ctr_x);
    yc = int'(ctr_y);
    xi = int'(pt_x);
    yi = int'(pt_y);
    done = region_two && (pt_y <= 0);

    push_pixel(xc + xi, yc + yi, 1'b0, 1'b0);
    push_pixel(xc - xi, yc + yi, 1'b0, 1'b0);
    push_pixel(xc - xi, yc - yi, 1'b0, 1'b0);
    push_pixel(xc + xi, yc - yi, 1'b1, done);

    if (done) begin
      tracing = 1'b0;
      return;
    end

    if (!region_two) begin
      pt_x = pt_x + 1;
      slope_x = slope_x + 2 * b2;
      if (dec < 0) begin
        dec = dec + 4 * (slope_x + b2);
      end else begin
        pt_y = pt_y - 1;
        slope_y = slope_y - 2 * a2;
        dec = dec + 4 * (slope_x - slope_y + b2);
      end
      if (slope_x >= slope_y) enter_region_two();
    end else begin
      pt_y = pt_y - 1;
      slope_y = slope_y - 2 * a2;
      if (dec > 0) begin
        dec = dec + 4 * (a2 - slope_y);
      end else begin
        pt_x = pt_x + 1;
        slope_x = slope_x + 2 * b2;
        dec = dec + 4 * (slope_x - slope_y + a2);
      end
    end
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result beats are checked before the same edge's command is predicted
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst_n) begin
      tracing = 1'b0;
      region_two = 1'b0;
      ctr_x = '0;
      ctr_y = '0;
      rad_x = '0;
      rad_y = '0;
      pt_x = 0;
      pt_y = 0;
      dec = 0;
      slope_x = 0;
      slope_y = 0;
      expected_pixels.delete();
      mismatch_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel beat (%0d, %0d) with nothing expected",
                 out_ch.pixel_x, out_ch.pixel_y);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", longint'($signed(want.px)),
                      longint'($signed(out_ch.pixel_x)));
          check_field("pixel_y", longint'($signed(want.py)),
                      longint'($signed(out_ch.pixel_y)));
          check_field("last_of_step", longint'(want.last), longint'(out_ch.last_of_step));
          check_field("ellipse_done", longint'(want.done), longint'(out_ch.ellipse_done));
        end
      end
      if (in_ch.valid && in_ch.ready)
        advance_ellipse(in_ch.cmd, in_ch.center_x, in_ch.center_y,
                        in_ch.radius_x, in_ch.radius_y);
    end
    pixels_owed = expected_pixels.size();
  end

endmodule

FILE: tb/tb_midpoint_ellipse_rasterizer.sv
module tb_midpoint_ellipse_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import mer_pkg::*;

  localparam int ITEM_TARGET   = 210;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int sender_idle_pct   = 18;
  int receiver_idle_pct = 48;
  int items_sent        = 0;
  bit hold_req          = 1'b0;
  int mismatch_count;
  int pixels_owed;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();

  midpoint_ellipse_rasterizer #(.RADIUS_BITS(RADIUS_BITS_DEF)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ellipse_pixel_checker #(.RADIUS_BITS(RADIUS_BITS_DEF)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pixels_owed    (pixels_owed)
  );

  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Pixel sink: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  function automatic logic [CRD_W-1:0] any_coord(input int hi);
    return CRD_W'($urandom_range(0, hi));
  endfunction

  // Drive one command beat and hold it until the block takes it
  task automatic send_beat(input logic cmd, input logic [CRD_W-1:0] cx,
                           input logic [CRD_W-1:0] cy, input logic [CRD_W-1:0] rx,
                           input logic [CRD_W-1:0] ry);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.cmd      <= cmd;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.radius_x <= rx;
    in_ch.radius_y <= ry;
    in_ch.valid    <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic draw_ellipse(input logic [CRD_W-1:0] cx, input logic [CRD_W-1:0] cy,
                              input logic [CRD_W-1:0] rx, input logic [CRD_W-1:0] ry,
                              input int steps);
    send_beat(CMD_START, cx, cy, rx, ry);
    repeat (steps)
      send_beat(CMD_STEP, any_coord(1023), any_coord(1023), any_coord(1023),
                any_coord(1023));
  endtask

  task automatic quiet_sender();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Drain everything, then switch the idle mix
  task automatic settle_phase(input int snd_pct, input int rcv_pct);
    quiet_sender();
    while (pixels_owed != 0) @(negedge clk);
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
  endtask

  initial begin
    int  phase;
    int  kind;
    int  rx, ry, n;
    bit  hold_done;
    phase = 0;
    hold_done = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_STEP;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.radius_x = '0;
    in_ch.radius_y = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: step with no ellipse, degenerate point, extremes, restart,
    // zero radii, one tiny full ellipse
    send_beat(CMD_STEP, '1, '1, '1, '1);
    draw_ellipse('0, '0, '0, '0, 1);
    send_beat(CMD_STEP, '0, '0, '0, '0);
    draw_ellipse(10'd1023, 10'd1023, 10'd1023, 10'd1023, 3);
    draw_ellipse('0, '0, 10'd1023, 10'd1023, 2);
    draw_ellipse(10'd512, 10'd300, 10'd0, 10'd5, 6);
    draw_ellipse(10'd700, 10'd100, 10'd5, 10'd0, 1);
    draw_ellipse(10'd1, 10'd2, 10'd2, 10'd1, 4);

    // Random: mostly complete small ellipses, some long thin ones,
    // some large ones cut short by a restart, and stray steps
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
        phase = 1;
        settle_phase(48, 18);
      end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        phase = 2;
        settle_phase(0, 0);
      end
      if (!hold_done && items_sent >= 50) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end

      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        rx = $urandom_range(0, 12);
        ry = $urandom_range(0, 12);
        n  = rx + ry + 2;
      end else if (kind == 6) begin
        if ($urandom_range(0, 1) == 0) begin
          rx = $urandom_range(0, 60);
          ry = $urandom_range(0, 4);
        end else begin
          rx = $urandom_range(0, 4);
          ry = $urandom_range(0, 60);
        end
        n = rx + ry + 2;
      end else if (kind <= 8) begin
        rx = $urandom_range(0, 1023);
        ry = $urandom_range(0, 1023);
        n  = $urandom_range(1, 6);
      end else begin
        repeat ($urandom_range(1, 3))
          send_beat(CMD_STEP, any_coord(1023), any_coord(1023), any_coord(1023),
                    any_coord(1023));
        continue;
      end
      draw_ellipse(any_coord(1023), any_coord(1023), CRD_W'(rx), CRD_W'(ry), n);
    end

    // Wind down
    quiet_sender();
    while (pixels_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
